/* sv/scc_pkg.sv */
// ----------------------------------------------------------------------------
// scc_pkg
// Shared widths, constants and pipeline item types of the spectral current
// correction core.
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int PART_BITS = 32;

	localparam int LANES   = 6;                          // x re, x im, y re, y im, z re, z im
	localparam int K_W     = 32;
	localparam int IDT_W   = 31;
	localparam int PROD_W  = K_W + PART_BITS;
	localparam int DRHO_W  = PART_BITS + 1;
	localparam int PDT_W   = DRHO_W + IDT_W + 1;
	localparam int T_W     = 67;
	localparam int MAG_W   = 66;
	localparam int MLO_W   = 33;
	localparam int MHI_W   = MAG_W - MLO_W;
	localparam int PP_W    = MLO_W + K_W;
	localparam int DEN_W   = 64;
	localparam int QUO_W   = 34;
	localparam int NUM_W   = MAG_W + K_W + 1;
	localparam int RES_W   = QUO_W + 2;
	localparam int IN_W    = 5 * 64 + 3 * K_W;
	localparam int OUT_W   = 192;
	localparam int USER_W  = 2;

	localparam logic [IDT_W-1:0] IDT_RESET = IDT_W'(64'd1 << FRAC_BITS);

	localparam logic signed [RES_W-1:0] PART_MAX = RES_W'((64'sd1 <<< (PART_BITS - 1)) - 64'sd1);
	localparam logic signed [RES_W-1:0] PART_MIN = -PART_MAX - RES_W'(1);

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] nq;   // numerator bits still to go, quotient bits shifted in
	} div_lane_t;

	typedef struct packed {
		div_lane_t [LANES-1:0]             lane;
		logic [DEN_W-1:0]                  den;
		logic [LANES-1:0][PART_BITS-1:0]   jpart;
		logic [LANES-1:0]                  neg;
		logic [LANES-1:0]                  ovf;
		logic                              corr;
	} div_item_t;

	typedef struct packed {
		logic skid_full;
		logic out_full;
	} out_stat_t;

endpackage

/* sv/scc_front.sv */
// ----------------------------------------------------------------------------
// scc_front
// Seven-stage front end: unpack, products, misfit sums, magnitudes, partial
// products, rounded numerators and the overflow check ahead of the divider.
// ----------------------------------------------------------------------------
module scc_front import scc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   in_data,
	input  logic [IDT_W-1:0]  idt,
	output logic              out_valid,
	output div_item_t         out_item
);

	logic [6:0] v_q;

	logic signed [PART_BITS-1:0] j_s1 [LANES];
	logic signed [K_W-1:0]       k_s1 [3];
	logic signed [DRHO_W-1:0]    dre_s1, dim_s1;

	logic signed [PROD_W-1:0]    kj_s2 [LANES];
	logic [DEN_W-1:0]            kk_s2 [3];
	logic signed [PDT_W-1:0]     pre_s2, pim_s2;
	logic signed [PART_BITS-1:0] j_s2 [LANES];
	logic signed [K_W-1:0]       k_s2 [3];

	logic signed [T_W-1:0]       tre_s3, tim_s3;
	logic [DEN_W-1:0]            knorm_s3;
	logic signed [PART_BITS-1:0] j_s3 [LANES];
	logic signed [K_W-1:0]       k_s3 [3];

	logic [MAG_W-1:0]            mag_s4 [LANES];
	logic [K_W-1:0]              kabs_s4 [LANES];
	logic [LANES-1:0]            neg_s4;
	logic [DEN_W-1:0]            den_s4;
	logic signed [PART_BITS-1:0] j_s4 [LANES];

	logic [PP_W-1:0]             plo_s5 [LANES];
	logic [PP_W-1:0]             phi_s5 [LANES];
	logic [LANES-1:0]            neg_s5;
	logic [DEN_W-1:0]            den_s5;
	logic signed [PART_BITS-1:0] j_s5 [LANES];

	logic [NUM_W-1:0]            num_s6 [LANES];
	logic [LANES-1:0]            neg_s6;
	logic [DEN_W-1:0]            den_s6;
	logic signed [PART_BITS-1:0] j_s6 [LANES];

	div_item_t                   item_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// unpack: real half high, imaginary half low
			for (int a = 0; a < 3; a++) begin
				j_s1[2*a]   <= in_data[64*a + 32 +: PART_BITS];
				j_s1[2*a+1] <= in_data[64*a +: PART_BITS];
				k_s1[a]     <= in_data[320 + K_W*a +: K_W];
			end
			dre_s1 <= DRHO_W'($signed(in_data[256 + 32 +: PART_BITS]))
				- DRHO_W'($signed(in_data[192 + 32 +: PART_BITS]));
			dim_s1 <= DRHO_W'($signed(in_data[256 +: PART_BITS]))
				- DRHO_W'($signed(in_data[192 +: PART_BITS]));

			for (int a = 0; a < 3; a++) begin
				kj_s2[2*a]   <= PROD_W'(k_s1[a]) * PROD_W'(j_s1[2*a]);
				kj_s2[2*a+1] <= PROD_W'(k_s1[a]) * PROD_W'(j_s1[2*a+1]);
				kk_s2[a]     <= DEN_W'(64'(k_s1[a]) * 64'(k_s1[a]));
				k_s2[a]      <= k_s1[a];
			end
			pre_s2 <= PDT_W'(dre_s1) * $signed({1'b0, idt});
			pim_s2 <= PDT_W'(dim_s1) * $signed({1'b0, idt});
			for (int l = 0; l < LANES; l++) j_s2[l] <= j_s1[l];

			tre_s3   <= T_W'(pim_s2) + T_W'(kj_s2[0]) + T_W'(kj_s2[2]) + T_W'(kj_s2[4]);
			tim_s3   <= T_W'(kj_s2[1]) + T_W'(kj_s2[3]) + T_W'(kj_s2[5]) - T_W'(pre_s2);
			knorm_s3 <= kk_s2[0] + kk_s2[1] + kk_s2[2];
			for (int a = 0; a < 3; a++) k_s3[a] <= k_s2[a];
			for (int l = 0; l < LANES; l++) j_s3[l] <= j_s2[l];

			for (int a = 0; a < 3; a++) begin
				mag_s4[2*a]    <= tre_s3[T_W-1] ? MAG_W'(-tre_s3) : MAG_W'(tre_s3);
				mag_s4[2*a+1]  <= tim_s3[T_W-1] ? MAG_W'(-tim_s3) : MAG_W'(tim_s3);
				kabs_s4[2*a]   <= k_s3[a][K_W-1] ? K_W'(-k_s3[a]) : K_W'(k_s3[a]);
				kabs_s4[2*a+1] <= k_s3[a][K_W-1] ? K_W'(-k_s3[a]) : K_W'(k_s3[a]);
				neg_s4[2*a]    <= tre_s3[T_W-1] ^ k_s3[a][K_W-1];
				neg_s4[2*a+1]  <= tim_s3[T_W-1] ^ k_s3[a][K_W-1];
			end
			den_s4 <= knorm_s3;
			for (int l = 0; l < LANES; l++) j_s4[l] <= j_s3[l];

			for (int l = 0; l < LANES; l++) begin
				plo_s5[l] <= PP_W'(mag_s4[l][MLO_W-1:0]) * PP_W'(kabs_s4[l]);
				phi_s5[l] <= PP_W'(mag_s4[l][MAG_W-1:MLO_W]) * PP_W'(kabs_s4[l]);
				j_s5[l]   <= j_s4[l];
			end
			neg_s5 <= neg_s4;
			den_s5 <= den_s4;

			// add half the divisor for round to nearest
			for (int l = 0; l < LANES; l++) begin
				num_s6[l] <= (NUM_W'(phi_s5[l]) << MLO_W) + NUM_W'(plo_s5[l])
					+ NUM_W'(den_s5 >> 1);
				j_s6[l]   <= j_s5[l];
			end
			neg_s6 <= neg_s5;
			den_s6 <= den_s5;

			for (int l = 0; l < LANES; l++) begin
				item_s7.ovf[l]      <= num_s6[l][NUM_W-1:QUO_W] >= {1'b0, den_s6};
				item_s7.lane[l].rem <= num_s6[l][QUO_W +: DEN_W];
				item_s7.lane[l].nq  <= num_s6[l][QUO_W-1:0];
				item_s7.jpart[l]    <= j_s6[l];
			end
			item_s7.neg  <= neg_s6;
			item_s7.den  <= den_s6;
			item_s7.corr <= den_s6 != '0;
		end
	end

	assign out_valid = v_q[6];
	assign out_item  = item_s7;

endmodule

/* sv/scc_div_step.sv */
// ----------------------------------------------------------------------------
// scc_div_step
// One restoring division step for all six lanes, registered.
// ----------------------------------------------------------------------------
module scc_div_step import scc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  div_item_t  in_item,
	output logic       out_valid,
	output div_item_t  out_item
);

	logic      v_s1;
	div_item_t item_s1;
	div_item_t nxt;

	always_comb begin
		logic [DEN_W:0] trial;
		logic           ge;
		nxt = in_item;
		for (int l = 0; l < LANES; l++) begin
			trial = {in_item.lane[l].rem, in_item.lane[l].nq[QUO_W-1]};
			ge    = trial >= {1'b0, in_item.den};
			nxt.lane[l].rem = ge ? DEN_W'(trial - {1'b0, in_item.den}) : trial[DEN_W-1:0];
			nxt.lane[l].nq  = {in_item.lane[l].nq[QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_item  = item_s1;

endmodule

/* sv/scc_back.sv */
// ----------------------------------------------------------------------------
// scc_back
// Sign, subtract and saturate per part, pack the result, and hold it in an
// output register with a skid entry behind it.
// ----------------------------------------------------------------------------
module scc_back import scc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  div_item_t          in_item,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,    // fixed_current_x, fixed_current_y,
	                                       // fixed_current_z
	output logic [USER_W-1:0]  m_tuser,    // was_corrected, clipped
	output out_stat_t          stat
);

	logic                    en;
	logic                    pop;
	logic                    rv_s1, ov_q, skv_q;
	logic [OUT_W+USER_W-1:0] res_s1, out_q, skid_q;
	logic [OUT_W+USER_W-1:0] res;

	always_comb begin
		logic signed [RES_W-1:0]     jx, v;
		logic signed [PART_BITS-1:0] p;
		logic [LANES-1:0]            clip;
		logic [LANES-1:0][31:0]      part;
		for (int l = 0; l < LANES; l++) begin
			jx = RES_W'($signed(in_item.jpart[l]));
			v  = in_item.neg[l] ? jx + $signed(RES_W'(in_item.lane[l].nq))
				: jx - $signed(RES_W'(in_item.lane[l].nq));
			clip[l] = 1'b1;
			if (!in_item.corr) begin
				p = in_item.jpart[l];
				clip[l] = 1'b0;
			end else if (in_item.ovf[l]) begin
				p = in_item.neg[l] ? PART_MAX[PART_BITS-1:0] : PART_MIN[PART_BITS-1:0];
			end else if (v > PART_MAX) begin
				p = PART_MAX[PART_BITS-1:0];
			end else if (v < PART_MIN) begin
				p = PART_MIN[PART_BITS-1:0];
			end else begin
				p = v[PART_BITS-1:0];
				clip[l] = 1'b0;
			end
			part[l] = 32'(p);
		end
		res = {|clip, in_item.corr,
			part[4], part[5], part[2], part[3], part[0], part[1]};
	end

	assign en  = !skv_q;
	assign pop = ov_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
			ov_q  <= 1'b0;
			skv_q <= 1'b0;
		end else begin
			if (en) rv_s1 <= in_valid;
			if (skv_q) begin
				if (pop) skv_q <= 1'b0;
			end else if (rv_s1) begin
				if (!ov_q || pop) ov_q <= 1'b1;
				else skv_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) res_s1 <= res;
		if (skv_q) begin
			if (pop) out_q <= skid_q;
		end else if (rv_s1) begin
			// park the request in the skid entry while the output is stalled
			if (!ov_q || pop) out_q <= res_s1;
			else skid_q <= res_s1;
		end
	end

	assign m_tvalid       = ov_q;
	assign m_tdata        = out_q[OUT_W-1:0];
	assign m_tuser        = out_q[OUT_W +: USER_W];
	assign stat.skid_full = skv_q;
	assign stat.out_full  = ov_q;

endmodule

/* sv/spectral_current_correction_core.sv */
// ----------------------------------------------------------------------------
// spectral_current_correction_core
// Path from an accepted request to m_tvalid: seven front stages, 34 divider
// steps, one saturation stage and one output register.
// Throughput: one grid point per cycle while s_tready is high; each quotient
// bit is one pipelined restoring step of the six-lane divider.
// Reset clears all valid bits and loads inverse_time_step with 1.0.
// ----------------------------------------------------------------------------
module spectral_current_correction_core import scc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,    // current_x, current_y, current_z, charge_old,
	                                       // charge_new, wave_x, wave_y, wave_z
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,    // fixed_current_x, fixed_current_y,
	                                       // fixed_current_z
	output logic [USER_W-1:0]  m_tuser,    // was_corrected, clipped
	input  logic               cfg_we,
	input  logic [IDT_W-1:0]   cfg_wdata
);

	logic [IDT_W-1:0] idt_q;
	logic             en;
	out_stat_t        stat;
	logic             in_valid;

	logic [QUO_W:0]   vchain;
	div_item_t        chain [QUO_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idt_q <= IDT_RESET;
		end else if (cfg_we) begin
			idt_q <= cfg_wdata;
		end
	end

	assign en       = !stat.skid_full;
	assign s_tready = en;
	assign in_valid = s_tvalid && en;

	scc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_data   (s_tdata),
		.idt       (idt_q),
		.out_valid (vchain[0]),
		.out_item  (chain[0])
	);

	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		scc_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vchain[i]),
			.in_item   (chain[i]),
			.out_valid (vchain[i+1]),
			.out_item  (chain[i+1])
		);
	end

	scc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vchain[QUO_W]),
		.in_item  (chain[QUO_W]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.stat     (stat)
	);

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		stat.skid_full |-> stat.out_full)
		else $error("skid entry holds a request with the output register empty");

	a_drain_keeps_out: assert property (@(posedge clk) disable iff (!arst_n)
		$past(stat.skid_full) && !stat.skid_full |-> m_tvalid)
		else $error("skid entry drained without refilling the output");

	a_pass_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> !m_tuser[1])
		else $error("pass-through result flagged as clipped");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Streams grid points through spectral_current_correction_core under several
// inverse time step settings and idling patterns. Each accepted request is
// predicted in a scoreboard and every result is checked field by field.
// ----------------------------------------------------------------------------
module testbench import scc_pkg::*; ();

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_WAIT = 60;
	localparam int RES_BITS   = OUT_W + USER_W;

	class correction_board;
		logic [IDT_W-1:0] idt;
		logic [RES_BITS-1:0] expected_q[$];
		int errors;

		function new();
			idt = IDT_RESET;
			errors = 0;
		endfunction

		function automatic longint part_of(logic [63:0] w, int sh);
			logic signed [31:0] p;
			p = w[sh+:32];
			return p;
		endfunction

		// j - t*k/|k|^2, rounded half away from zero, saturated to 32 bits
		function automatic logic [31:0] fix_part(longint j, logic signed [127:0] t,
				longint k, logic [63:0] kn, inout bit clip);
			logic [127:0] mag, num, q;
			logic [63:0] kabs;
			bit neg;
			longint v;
			mag = (t < 0) ? -t : t;
			kabs = (k < 0) ? -k : k;
			neg = (t < 0) != (k < 0);
			num = mag * {64'd0, kabs} + {64'd0, kn >> 1};
			q = num / {64'd0, kn};
			if (q > (128'd1 << 62)) begin
				clip = 1;
				return neg ? 32'h7fffffff : 32'h80000000;
			end
			v = neg ? j + longint'(q[63:0]) : j - longint'(q[63:0]);
			if (v > 64'sh7fffffff) begin
				clip = 1;
				return 32'h7fffffff;
			end
			if (v < -64'sh80000000) begin
				clip = 1;
				return 32'h80000000;
			end
			return v[31:0];
		endfunction

		function void note_request(logic [IN_W-1:0] d);
			longint jr[3], ji[3], k[3];
			longint dre, dim;
			logic [63:0] kn;
			logic signed [127:0] tre, tim;
			logic [RES_BITS-1:0] r;
			bit clip;
			r = '0;
			kn = '0;
			clip = 0;
			for (int a = 0; a < 3; a++) begin
				jr[a] = part_of(d[64*a+:64], 32);
				ji[a] = part_of(d[64*a+:64], 0);
				k[a] = longint'($signed(d[320+32*a+:32]));
				kn += k[a] * k[a];
			end
			dre = part_of(d[256+:64], 32) - part_of(d[192+:64], 32);
			dim = part_of(d[256+:64], 0) - part_of(d[192+:64], 0);
			if (kn == 0) begin
				for (int a = 0; a < 3; a++)
					r[64*a+:64] = {jr[a][31:0], ji[a][31:0]};
			end else begin
				tre = dim * longint'(idt);
				tim = -(dre * longint'(idt));
				for (int a = 0; a < 3; a++) begin
					tre = tre + k[a] * jr[a];
					tim = tim + k[a] * ji[a];
				end
				for (int a = 0; a < 3; a++) begin
					r[64*a+32+:32] = fix_part(jr[a], tre, k[a], kn, clip);
					r[64*a+:32] = fix_part(ji[a], tim, k[a], kn, clip);
				end
				r[192] = 1'b1;
				r[193] = clip;
			end
			expected_q.push_back(r);
		endfunction

		function void field_check(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_result(logic [RES_BITS-1:0] d);
			logic [RES_BITS-1:0] e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none actual %h", $time, d);
				return;
			end
			e = expected_q.pop_front();
			field_check("fixed_current_x", e[63:0], d[63:0]);
			field_check("fixed_current_y", e[127:64], d[127:64]);
			field_check("fixed_current_z", e[191:128], d[191:128]);
			field_check("was_corrected", e[192], d[192]);
			field_check("clipped", e[193], d[193]);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [USER_W-1:0] m_tuser;
	logic cfg_we;
	logic [IDT_W-1:0] cfg_wdata;

	correction_board board;
	int send_idle;
	int recv_stall;
	int quiet_cycles;

	spectral_current_correction_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: check each accepted result, then stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result({m_tuser, m_tdata});
		m_tready <= arst_n && ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic logic [63:0] cplx(longint re, longint im);
		return {re[31:0], im[31:0]};
	endfunction

	function automatic logic [IN_W-1:0] point(logic [63:0] jx, logic [63:0] jy,
			logic [63:0] jz, logic [63:0] ro, logic [63:0] rn,
			logic [31:0] kx, logic [31:0] ky, logic [31:0] kz);
		return {kz, ky, kx, rn, ro, jz, jy, jx};
	endfunction

	function automatic logic [31:0] rand_part(int bits);
		longint v;
		v = longint'($urandom_range((1 << bits) - 1)) - (longint'(1) << (bits - 1));
		return v[31:0];
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [IN_W-1:0] random_point();
		logic [IN_W-1:0] d;
		int mode;
		mode = $urandom_range(99);
		if (mode < 25) begin
			for (int i = 0; i < IN_W / 32; i++)
				d[32*i+:32] = $urandom();
		end else begin
			for (int i = 0; i < 10; i++)
				d[32*i+:32] = rand_part(21);
			for (int a = 0; a < 3; a++)
				d[320+32*a+:32] = ($urandom_range(5) == 0) ? 32'd0 : rand_part(19);
			if ($urandom_range(3) == 0)
				d[352+:32] = '0;
			if (mode < 35)
				d[320+:96] = '0;
			else if (mode < 45) begin
				d[320+:96] = '0;
				d[320+32*$urandom_range(2)+:32] = $urandom_range(1) ? 32'd1 : 32'hffffffff;
				for (int i = 0; i < 10; i++)
					d[32*i+:32] = $urandom();
			end
		end
		return d;
	endfunction

	task automatic push_point(input logic [IN_W-1:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_request(d);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_idt(input logic [IDT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.idt = v;
	endtask

	task automatic run_directed();
		logic [63:0] jmax, jmin;
		jmax = cplx(64'sh7fffffff, 64'sh7fffffff);
		jmin = cplx(-64'sh80000000, -64'sh80000000);
		// zero wave vector passes the current through
		push_point(point(jmax, jmin, cplx(5, -7), rand_word(), rand_word(), 0, 0, 0));
		push_point(point(jmin, jmax, 64'hffffffffffffffff, jmax, jmin, 0, 0, 0));
		// simple projection cases
		push_point(point(cplx(1 << 16, 0), 0, 0, 0, 0, 1 << 16, 0, 0));
		push_point(point(cplx(3 << 16, 1 << 15), cplx(-2 << 16, 7), cplx(9, -9),
			cplx(1 << 16, 2), cplx(3 << 16, -5), 1 << 14, -(1 << 13), 3 << 12));
		// two-dimensional grid, wave_y zero
		push_point(point(cplx(1000, -1000), cplx(777, 1), cplx(-3, 4), cplx(10, 20),
			cplx(-30, 40), 12345, 0, -54321));
		// extreme wave vectors
		push_point(point(jmax, jmax, jmax, jmin, jmax, 32'h80000000, 32'h80000000,
			32'h80000000));
		push_point(point(jmin, jmin, jmin, jmax, jmin, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff));
		push_point(point(jmax, jmin, jmax, jmax, jmin, 32'h80000000, 32'h7fffffff, 0));
		// tiny wave vector with large current gives a huge correction
		push_point(point(jmax, jmin, jmax, 0, jmax, 1, 0, 0));
		push_point(point(jmin, jmax, jmin, jmax, 0, 0, 32'hffffffff, 0));
		push_point(point(cplx(100, 100), 0, 0, 0, 0, 0, 0, 1));
		// small cases in which the rounded division comes out exact
		push_point(point(cplx(1, -1), cplx(1, 1), 0, 0, 0, 2, 2, 0));
		push_point(point(cplx(3, -3), 0, 0, 0, 0, 2, 0, 0));
		push_point(point(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
			$urandom(), $urandom(), $urandom()));
	endtask

	initial begin
		logic [IDT_W-1:0] idt_set[5];
		int idle_set[5];
		int stall_set[5];
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		send_idle = 0;
		recv_stall = 0;
		quiet_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		write_idt('0);
		run_directed();
		write_idt({IDT_W{1'b1}});
		run_directed();

		idt_set = '{IDT_RESET, {IDT_W{1'b1}}, '0, IDT_W'($urandom()), IDT_W'($urandom_range(1 << 20))};
		idle_set = '{0, 78, 0, 20, 0};
		stall_set = '{0, 0, 78, 20, 0};
		for (int ph = 0; ph < 5; ph++) begin
			write_idt(idt_set[ph]);
			send_idle = idle_set[ph];
			recv_stall = stall_set[ph];
			for (int n = 0; n < 82; n++) begin
				if (n == 41 && ph == 3) begin
					// hold off until the pipeline is empty
					s_tvalid <= 1'b0;
					while (board.expected_q.size() != 0)
						@(posedge clk);
				end
				push_point(random_point());
			end
		end

		recv_stall = 0;
		drain();
		if (board.errors == 0 && board.expected_q.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/scc_pkg.sv
sv/scc_front.sv
sv/scc_div_step.sv
sv/scc_back.sv
sv/spectral_current_correction_core.sv
bench/testbench.sv
